// ----- design/ssfr_pkg.sv -----
// shared types, codes and constants of the serial status frame receiver
// used by every module in design/, depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package ssfr_pkg;

	// input commands
	localparam logic [1:0] CMD_BYTE    = 2'd0;
	localparam logic [1:0] CMD_TICK    = 2'd1;
	localparam logic [1:0] CMD_TRIGGER = 2'd2;

	// result event codes
	localparam logic [2:0] EV_GOOD      = 3'd0;
	localparam logic [2:0] EV_TAIL_ERR  = 3'd1;
	localparam logic [2:0] EV_SUM_ERR   = 3'd2;
	localparam logic [2:0] EV_CONFIRMED = 3'd3;
	localparam logic [2:0] EV_TIMED_OUT = 3'd4;

	// configuration register indexes
	localparam logic CFG_TIMEOUT_TICKS    = 1'b0;
	localparam logic CFG_ASCII_BYTE_LIMIT = 1'b1;

	localparam logic [15:0] TIMEOUT_TICKS_RST    = 16'd500;
	localparam logic [7:0]  ASCII_BYTE_LIMIT_RST = 8'd128;

	// frame layout
	localparam logic [7:0] HDR_BYTE    = 8'h71;
	localparam logic [7:0] TAIL_BYTE   = 8'h5C;
	localparam logic [7:0] GEN_NORMAL  = 8'h01;
	localparam logic [7:0] GEN_ABNORM  = 8'h02;
	localparam int         STORE_DEPTH = 5;

	// confirmation phrase "finish open"
	localparam logic [3:0] PHRASE_LEN  = 4'd11;
	localparam logic [3:0] PHRASE_LAST = 4'd10;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic       report_valid;
		logic       generator_ok;
		logic [7:0] payload_one;
		logic [7:0] payload_two;
		logic [7:0] payload_three;
		logic [7:0] gen_state_byte;
	} result_t;

	typedef struct packed {
		logic [15:0] timeout_ticks;
		logic [7:0]  ascii_byte_limit;
	} cfg_t;

	function automatic logic [7:0] phrase_char(input logic [3:0] idx);
		logic [7:0] c;
		unique case (idx)
			4'd0:    c = "f";
			4'd1:    c = "i";
			4'd2:    c = "n";
			4'd3:    c = "i";
			4'd4:    c = "s";
			4'd5:    c = "h";
			4'd6:    c = " ";
			4'd7:    c = "o";
			4'd8:    c = "p";
			4'd9:    c = "e";
			4'd10:   c = "n";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- design/serial_status_frame_receiver_unit.sv -----
// top level of the serial status frame receiver: configuration registers and stage wiring
// depends on ssfr_pkg, ssfr_in_stage, ssfr_core, ssfr_out_reg
`timescale 1ns / 1ps
`default_nettype none

// Serial status frame receiver. Each transaction on the item channel carries one
// command: a received UART byte, a time tick or a trigger notice. Bytes are parsed
// for a 7-byte frame (header 0x71, three payload bytes, generator status byte,
// 8-bit additive checksum over bytes 0..4, tail 0x5C); a finished frame yields one
// result transaction: good frame (with payload and generator status), tail error
// or checksum error. A trigger arms a wait loaded from timeout_ticks; while armed
// the text "finish open" in the byte stream yields a confirmed result and ticks
// count down to a timed-out result. A run of ascii_byte_limit unmatched bytes
// while armed clears the match progress and any partial frame. Items produce zero
// or one result. Timing: an item is held in the input register, and its result
// is registered in the result register once that register can take it; one item
// is taken every clock as long as the result register drains. Configuration
// writes take effect on the next clock and are to be made while idle by the user;
// the block itself does not enforce this.
module serial_status_frame_receiver_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// item channel
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire ssfr_pkg::item_t   item,
	// result channel
	output logic                   result_valid,
	input  wire logic              result_ready,
	output ssfr_pkg::result_t      result,
	// configuration write port
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [15:0]       cfg_data
);

	ssfr_pkg::cfg_t    cfg_q;
	ssfr_pkg::item_t   item_s1;
	ssfr_pkg::result_t res;
	logic              valid_s1;
	logic              advance;
	logic              fire;
	logic              hit;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks    <= ssfr_pkg::TIMEOUT_TICKS_RST;
			cfg_q.ascii_byte_limit <= ssfr_pkg::ASCII_BYTE_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ssfr_pkg::CFG_TIMEOUT_TICKS:    cfg_q.timeout_ticks    <= cfg_data;
				ssfr_pkg::CFG_ASCII_BYTE_LIMIT: cfg_q.ascii_byte_limit <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// held item is processed once the result register can take whatever it makes
	assign fire = valid_s1 && advance;

	ssfr_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	// parser, phrase matcher and deadline state update once per item
	ssfr_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item_s1 (item_s1),
		.cfg     (cfg_q),
		.hit     (hit),
		.res     (res)
	);

	// result register doubles as the output skid stage
	ssfr_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (fire && hit),
		.res          (res),
		.free         (advance),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire

// ----- design/ssfr_in_stage.sv -----
// input register of the serial status frame receiver
// depends on ssfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module ssfr_in_stage (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           item_valid,
	output logic                item_ready,
	input  wire ssfr_pkg::item_t item,
	input  wire logic           advance,
	output logic                valid_s1,
	output ssfr_pkg::item_t     item_s1
);

	// stage frees itself whenever the held item moves on
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

endmodule

`default_nettype wire

// ----- design/ssfr_core.sv -----
// frame parser, phrase matcher and time-out counter state with next-state logic
// depends on ssfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module ssfr_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            fire,
	input  wire ssfr_pkg::item_t item_s1,
	input  wire ssfr_pkg::cfg_t  cfg,
	output logic                 hit,
	output ssfr_pkg::result_t    res
);

	logic [7:0]  store_q [ssfr_pkg::STORE_DEPTH];
	logic [2:0]  pos_q, pos_n;
	logic [7:0]  sum_q, sum_n;
	logic        armed_q, armed_n;
	logic [15:0] ticks_q, ticks_n;
	logic [3:0]  mi_q, mi_n;
	logic [7:0]  unm_q, unm_n;

	logic        store_we;
	logic [2:0]  store_idx;
	logic        done;
	logic [3:0]  mi_sel;
	logic [7:0]  unm_inc;
	logic [7:0]  lim;
	logic [7:0]  b;

	assign b         = item_s1.data_byte;
	assign store_idx = pos_q - 3'd1;
	assign mi_sel    = (mi_q < ssfr_pkg::PHRASE_LEN) ? mi_q : 4'd0;
	assign unm_inc   = unm_q + 8'd1;
	assign lim       = (cfg.ascii_byte_limit == 8'd0) ? 8'd1 : cfg.ascii_byte_limit;

	always_comb begin
		pos_n    = pos_q;
		sum_n    = sum_q;
		armed_n  = armed_q;
		ticks_n  = ticks_q;
		mi_n     = mi_q;
		unm_n    = unm_q;
		store_we = 1'b0;
		done     = 1'b0;
		hit      = 1'b0;
		res      = '0;
		unique case (item_s1.cmd)
			ssfr_pkg::CMD_BYTE: begin
				if (armed_q) begin
					if (b == ssfr_pkg::phrase_char(mi_sel)) begin
						unm_n = 8'd0;
						if (mi_sel == ssfr_pkg::PHRASE_LAST) begin
							armed_n          = 1'b0;
							mi_n             = 4'd0;
							pos_n            = 3'd0;
							sum_n            = 8'd0;
							done             = 1'b1;
							hit              = 1'b1;
							res.event_res    = ssfr_pkg::EV_CONFIRMED;
							res.report_valid = 1'b1;
							res.generator_ok = 1'b1;
						end else begin
							mi_n = mi_sel + 4'd1;
						end
					end else begin
						mi_n = (b == ssfr_pkg::phrase_char(4'd0)) ? 4'd1 : 4'd0;
						if (unm_inc >= lim) begin
							// run too long: drop byte, partial frame and progress
							unm_n = 8'd0;
							mi_n  = 4'd0;
							pos_n = 3'd0;
							sum_n = 8'd0;
							done  = 1'b1;
						end else begin
							unm_n = unm_inc;
						end
					end
				end
				if (!done) begin
					if (pos_q == 3'd0) begin
						if (b == ssfr_pkg::HDR_BYTE) begin
							pos_n = 3'd1;
							sum_n = ssfr_pkg::HDR_BYTE;
						end
					end else if (pos_q <= 3'd5) begin
						store_we = 1'b1;
						if (pos_q <= 3'd4) begin
							sum_n = sum_q + b;
						end
						pos_n = pos_q + 3'd1;
					end else begin
						// tail position: frame ends here either way
						pos_n = 3'd0;
						sum_n = 8'd0;
						hit   = 1'b1;
						if (b != ssfr_pkg::TAIL_BYTE) begin
							res.event_res = ssfr_pkg::EV_TAIL_ERR;
						end else if (sum_q != store_q[4]) begin
							res.event_res = ssfr_pkg::EV_SUM_ERR;
						end else begin
							res.event_res      = ssfr_pkg::EV_GOOD;
							res.report_valid   = (store_q[3] == ssfr_pkg::GEN_NORMAL)
								|| (store_q[3] == ssfr_pkg::GEN_ABNORM);
							res.generator_ok   = (store_q[3] == ssfr_pkg::GEN_NORMAL);
							res.payload_one    = store_q[0];
							res.payload_two    = store_q[1];
							res.payload_three  = store_q[2];
							res.gen_state_byte = store_q[3];
						end
					end
				end
			end
			ssfr_pkg::CMD_TICK: begin
				if (armed_q) begin
					if (ticks_q <= 16'd1) begin
						ticks_n          = 16'd0;
						armed_n          = 1'b0;
						mi_n             = 4'd0;
						unm_n            = 8'd0;
						hit              = 1'b1;
						res.event_res    = ssfr_pkg::EV_TIMED_OUT;
						res.report_valid = 1'b1;
					end else begin
						ticks_n = ticks_q - 16'd1;
					end
				end
			end
			ssfr_pkg::CMD_TRIGGER: begin
				armed_n = 1'b1;
				ticks_n = cfg.timeout_ticks;
				mi_n    = 4'd0;
				unm_n   = 8'd0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 3'd0;
			sum_q   <= 8'd0;
			armed_q <= 1'b0;
			ticks_q <= 16'd0;
			mi_q    <= 4'd0;
			unm_q   <= 8'd0;
		end else if (fire) begin
			pos_q   <= pos_n;
			sum_q   <= sum_n;
			armed_q <= armed_n;
			ticks_q <= ticks_n;
			mi_q    <= mi_n;
			unm_q   <= unm_n;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && store_we) begin
			store_q[store_idx] <= b;
		end
	end

endmodule

`default_nettype wire

// ----- design/ssfr_out_reg.sv -----
// result register of the serial status frame receiver
// depends on ssfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module ssfr_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire ssfr_pkg::result_t res,
	output logic                   free,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output ssfr_pkg::result_t      result
);

	logic              valid_q;
	ssfr_pkg::result_t result_q;

	assign free         = !valid_q || result_ready;
	assign result_valid = valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= res;
		end
	end

endmodule

`default_nettype wire

// ----- test/tb_serial_status_frame_receiver_unit.sv -----
// testbench for serial_status_frame_receiver_unit: directed and random command streams
// checked against a built-in predictor of frame parsing and confirmation wait
// depends on ssfr_pkg and the design files under design/
`timescale 1ns / 1ps

module tb_serial_status_frame_receiver_unit;
	import ssfr_pkg::*;

	// command code outside the defined set, must be ignored
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	// confirmation text, first character in the top byte
	localparam logic [87:0] CONFIRM_TEXT = "finish open";
	localparam int CONFIRM_LEN = 11;
	// cycles after the last expected result before the block counts as idle
	localparam int DRAIN_CYCLES = 6;
	// cycles with no transaction on either channel before giving up
	localparam int STALL_LIMIT = 2000;
	// length of the long receiver hold-off
	localparam int HOLD_CYCLES = 150;
	localparam int RANDOM_PHASES = 7;
	localparam int PHASE_ITEMS = 250;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	result_t result;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;

	// predictor state: configuration copy and receiver state
	logic [15:0] cfg_timeout = TIMEOUT_TICKS_RST;
	logic [7:0] cfg_limit = ASCII_BYTE_LIMIT_RST;
	logic [7:0] frame_bytes [0:4];
	logic [2:0] parse_pos = '0;
	bit arm_active = 1'b0;
	logic [15:0] ticks_remaining = '0;
	logic [3:0] phrase_pos = '0;
	logic [7:0] miss_run = '0;

	result_t expected_events [$];
	int mismatches = 0;
	int items_sent = 0;
	int idle_cycles = 0;
	bit gaps_on = 1'b1;
	int hold_request = 0;
	int hold_left = 0;
	int stall_left = 0;

	serial_status_frame_receiver_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic logic [7:0] phrase_at(input int idx);
		return CONFIRM_TEXT[8 * (CONFIRM_LEN - 1 - idx) +: 8];
	endfunction

	// one received byte: confirmation matching while armed, then frame parsing
	function automatic bit decode_byte(input logic [7:0] b, output result_t ev);
		logic [3:0] pi;
		logic [7:0] lim;
		logic [7:0] chk;
		logic [7:0] gs;
		ev = '0;
		if (arm_active) begin
			pi = (phrase_pos < CONFIRM_LEN) ? phrase_pos : 4'd0;
			if (b == phrase_at(pi)) begin
				phrase_pos = pi + 4'd1;
				miss_run = '0;
				if (phrase_pos >= CONFIRM_LEN) begin
					// confirmed: wait ends, any partial frame goes too
					arm_active = 1'b0;
					phrase_pos = '0;
					parse_pos = '0;
					ev.event_res = EV_CONFIRMED;
					ev.report_valid = 1'b1;
					ev.generator_ok = 1'b1;
					return 1'b1;
				end
			end else begin
				lim = (cfg_limit == 8'd0) ? 8'd1 : cfg_limit;
				// a stray 'f' may start the text again
				phrase_pos = (b == phrase_at(0)) ? 4'd1 : 4'd0;
				miss_run = miss_run + 8'd1;
				if (miss_run >= lim) begin
					// run too long: byte dropped with match progress and partial frame
					miss_run = '0;
					phrase_pos = '0;
					parse_pos = '0;
					return 1'b0;
				end
			end
		end
		if (parse_pos == 3'd0) begin
			if (b == HDR_BYTE)
				parse_pos = 3'd1;
			return 1'b0;
		end
		if (parse_pos <= 3'd5) begin
			frame_bytes[parse_pos - 3'd1] = b;
			parse_pos = parse_pos + 3'd1;
			return 1'b0;
		end
		// tail position: tail checked first, then checksum
		parse_pos = '0;
		if (b != TAIL_BYTE) begin
			ev.event_res = EV_TAIL_ERR;
			return 1'b1;
		end
		chk = HDR_BYTE + frame_bytes[0] + frame_bytes[1] + frame_bytes[2] + frame_bytes[3];
		if (chk != frame_bytes[4]) begin
			ev.event_res = EV_SUM_ERR;
			return 1'b1;
		end
		gs = frame_bytes[3];
		ev.event_res = EV_GOOD;
		ev.report_valid = (gs == GEN_NORMAL) || (gs == GEN_ABNORM);
		ev.generator_ok = (gs == GEN_NORMAL);
		ev.payload_one = frame_bytes[0];
		ev.payload_two = frame_bytes[1];
		ev.payload_three = frame_bytes[2];
		ev.gen_state_byte = gs;
		return 1'b1;
	endfunction

	// advance the predictor by one accepted transaction
	function automatic void predict_event(input item_t it);
		result_t ev;
		bit hit;
		ev = '0;
		hit = 1'b0;
		case (it.cmd)
			CMD_BYTE: begin
				hit = decode_byte(it.data_byte, ev);
			end
			CMD_TICK: begin
				if (arm_active) begin
					if (ticks_remaining <= 16'd1) begin
						ticks_remaining = '0;
						arm_active = 1'b0;
						phrase_pos = '0;
						miss_run = '0;
						ev.event_res = EV_TIMED_OUT;
						ev.report_valid = 1'b1;
						hit = 1'b1;
					end else begin
						ticks_remaining = ticks_remaining - 16'd1;
					end
				end
			end
			CMD_TRIGGER: begin
				arm_active = 1'b1;
				ticks_remaining = cfg_timeout;
				phrase_pos = '0;
				miss_run = '0;
			end
			default: begin
			end
		endcase
		if (hit)
			expected_events.insert(expected_events.size(), ev);
	endfunction

	// offer one transaction, optionally after a short gap, and wait for acceptance
	task automatic send_item(input logic [1:0] cmd, input logic [7:0] data);
		item_t it;
		int gap;
		it.cmd = cmd;
		it.data_byte = data;
		gap = (gaps_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : 0;
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!item_ready);
		predict_event(it);
		items_sent++;
	endtask

	// full frame; checksum and tail computed here, optionally corrupted
	task automatic send_frame(input logic [7:0] p1, input logic [7:0] p2, input logic [7:0] p3,
			input logic [7:0] gs, input bit bad_sum, input bit bad_tail);
		logic [7:0] chk;
		logic [7:0] tail;
		chk = HDR_BYTE + p1 + p2 + p3 + gs;
		if (bad_sum)
			chk = chk ^ (8'd1 << $urandom_range(0, 7));
		tail = bad_tail ? (TAIL_BYTE ^ 8'($urandom_range(1, 255))) : TAIL_BYTE;
		send_item(CMD_BYTE, HDR_BYTE);
		send_item(CMD_BYTE, p1);
		send_item(CMD_BYTE, p2);
		send_item(CMD_BYTE, p3);
		send_item(CMD_BYTE, gs);
		send_item(CMD_BYTE, chk);
		send_item(CMD_BYTE, tail);
	endtask

	// first n characters of the confirmation text, one of them spoiled if asked
	task automatic send_phrase(input int n, input int spoil_at);
		for (int i = 0; i < n; i++) begin
			if (i == spoil_at)
				send_item(CMD_BYTE, phrase_at(i) ^ 8'($urandom_range(1, 255)));
			else
				send_item(CMD_BYTE, phrase_at(i));
		end
	endtask

	// stop offering, let every expected result arrive, then let the pipeline empty
	task automatic wait_idle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// register write, only called while the block is idle
	task automatic write_cfg(input logic idx, input logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == CFG_TIMEOUT_TICKS)
			cfg_timeout = value;
		else
			cfg_limit = value[7:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// frame outcomes: good with normal and abnormal status, tail and checksum errors
	task automatic test_frame_checks();
		send_frame(8'hFF, 8'h00, 8'hFF, GEN_NORMAL, 1'b0, 1'b0);
		// header value inside the payload must not resync
		send_frame(HDR_BYTE, HDR_BYTE, HDR_BYTE, GEN_ABNORM, 1'b0, 1'b0);
		send_frame(8'h00, 8'hFF, 8'h00, GEN_NORMAL, 1'b0, 1'b1);
		send_frame(8'h12, 8'h34, 8'h56, 8'hFF, 1'b1, 1'b0);
		wait_idle();
	endtask

	// ignored commands, zero timeout and zero byte limit, countdown through one
	task automatic test_timeout_extremes();
		write_cfg(CFG_TIMEOUT_TICKS, 16'd0);
		write_cfg(CFG_ASCII_BYTE_LIMIT, 16'd0);
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_UNUSED, 8'hFF);
		send_item(CMD_TRIGGER, 8'h00);
		// limit of zero behaves as one: header dropped at once
		send_item(CMD_BYTE, HDR_BYTE);
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_TRIGGER, 8'hFF);
		send_item(CMD_BYTE, phrase_at(0));
		send_item(CMD_TICK, 8'h00);
		wait_idle();
		write_cfg(CFG_TIMEOUT_TICKS, 16'd2);
		write_cfg(CFG_ASCII_BYTE_LIMIT, 16'd3);
		// third unmatched byte clears the frame started by the header
		send_item(CMD_TRIGGER, 8'h00);
		send_item(CMD_BYTE, HDR_BYTE);
		send_item(CMD_BYTE, 8'h12);
		send_item(CMD_BYTE, 8'h34);
		send_item(CMD_TICK, 8'h00);
		send_item(CMD_TICK, 8'h00);
		wait_idle();
	endtask

	// confirmation text with a broken start, and a tail error in the middle of it
	task automatic test_confirmation();
		write_cfg(CFG_TIMEOUT_TICKS, 16'hFFFF);
		write_cfg(CFG_ASCII_BYTE_LIMIT, 16'd255);
		send_item(CMD_TRIGGER, 8'h00);
		send_item(CMD_BYTE, HDR_BYTE);
		send_item(CMD_BYTE, phrase_at(0));
		send_item(CMD_BYTE, phrase_at(1));
		send_phrase(CONFIRM_LEN, -1);
		send_item(CMD_TICK, 8'h00);
		wait_idle();
	endtask

	// long receiver hold-off while good frames keep coming, block must stall its input
	task automatic test_backpressure();
		gaps_on = 1'b0;
		hold_request = HOLD_CYCLES;
		for (int i = 0; i < 15; i++)
			send_frame(8'($urandom), 8'($urandom), 8'($urandom), GEN_NORMAL, 1'b0, 1'b0);
		wait_idle();
		gaps_on = 1'b1;
	endtask

	// mostly well-formed frames and confirmation attempts, mixed with noise
	task automatic random_traffic(input int n);
		int stop_at;
		int pick;
		logic [7:0] gs;
		stop_at = items_sent + n;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 35) begin
				case ($urandom_range(0, 3))
					0: gs = GEN_NORMAL;
					1: gs = GEN_ABNORM;
					2: gs = 8'd0;
					default: gs = 8'($urandom);
				endcase
				send_frame(8'($urandom), 8'($urandom), 8'($urandom), gs,
					$urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
			end else if (pick < 50) begin
				if ($urandom_range(0, 1) == 0)
					send_item(CMD_TRIGGER, 8'($urandom));
				send_phrase(($urandom_range(0, 4) == 0) ? $urandom_range(1, CONFIRM_LEN - 1)
					: CONFIRM_LEN, ($urandom_range(0, 6) == 0)
					? $urandom_range(0, CONFIRM_LEN - 1) : -1);
			end else if (pick < 60) begin
				send_item(CMD_TRIGGER, 8'($urandom));
			end else if (pick < 75) begin
				repeat ($urandom_range(1, 8)) send_item(CMD_TICK, 8'($urandom));
			end else if (pick < 92) begin
				repeat ($urandom_range(1, 6))
					send_item(CMD_BYTE, ($urandom_range(0, 7) == 0) ? HDR_BYTE : 8'($urandom));
			end else begin
				send_item(CMD_UNUSED, 8'($urandom));
			end
		end
	endtask

	// several register settings, idling switched off for the last phase
	task automatic test_random_traffic();
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case ($urandom_range(0, 3))
				0: write_cfg(CFG_TIMEOUT_TICKS, 16'd1);
				1: write_cfg(CFG_TIMEOUT_TICKS, 16'd2);
				default: write_cfg(CFG_TIMEOUT_TICKS, 16'($urandom_range(3, 40)));
			endcase
			case ($urandom_range(0, 4))
				0: write_cfg(CFG_ASCII_BYTE_LIMIT, 16'd1);
				1: write_cfg(CFG_ASCII_BYTE_LIMIT, 16'd255);
				default: write_cfg(CFG_ASCII_BYTE_LIMIT, 16'($urandom_range(2, 24)));
			endcase
			gaps_on = (ph < RANDOM_PHASES - 1);
			random_traffic(PHASE_ITEMS);
			wait_idle();
		end
	endtask

	// result side: random stall bursts, plus the long hold-off when requested
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 5);
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	// every accepted result transaction against the oldest expectation
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_events.size() == 0) begin
				$error("result transaction with none expected, event_res %0d", result.event_res);
				mismatches++;
			end else begin
				want = expected_events.pop_front();
				check_field("event_res", want.event_res, result.event_res);
				check_field("report_valid", want.report_valid, result.report_valid);
				check_field("generator_ok", want.generator_ok, result.generator_ok);
				check_field("payload_one", want.payload_one, result.payload_one);
				check_field("payload_two", want.payload_two, result.payload_two);
				check_field("payload_three", want.payload_three, result.payload_three);
				check_field("gen_state_byte", want.gen_state_byte, result.gen_state_byte);
			end
		end
	end

	// watchdog: too long without any transaction on either channel
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$error("no transaction for %0d cycles, %0d results outstanding",
				STALL_LIMIT, expected_events.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_frame_checks();
		test_timeout_extremes();
		test_confirmation();
		test_backpressure();
		test_random_traffic();
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
